### rtl/core/erpl_pkg.sv
package erpl_pkg;

    // Distance window in centimeters
    localparam logic [10:0] DIST_MIN_CM = 11'd12;
    localparam logic [10:0] DIST_MAX_CM = 11'd46;
    localparam logic [5:0]  SPAN_CM     = 6'd34;

    // Reset value of the blink interval
    localparam logic [15:0] BLINK_INTERVAL_RST = 16'd100;

    // floor(pulse * 5 / 291) = (pulse * 5 * 461230) >> 27, exact for pulse < 2^16
    localparam logic [21:0] DIST_MAGIC = 22'd2306150;
    localparam int          DIST_SHIFT = 27;

    // floor(v * 50 / 17) = (v * 50 * 3856) >> 16, exact for v <= 34
    localparam logic [17:0] PCT_MAGIC = 18'd192800;
    localparam int          PCT_SHIFT = 16;

    // floor(pct * 229 / 100) = (pct * 229 * 41944) >> 22, exact for pct <= 100
    localparam logic [23:0] PWM_MAGIC = 24'd9605176;
    localparam int          PWM_SHIFT = 22;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // One classified request waiting for the back end
    typedef struct packed {
        logic [10:0] dist_cm;
        logic [5:0]  offset;
        logic        outside;
        logic [31:0] time_ms;
    } t_entry;

    // Queue occupancy seen by both ends
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

### rtl/core/echo_range_to_pwm_level.sv
// Echo range to PWM level. Each request carries an echo width in microseconds
// and its millisecond timestamp; each result gives the distance in cm
// (floor(width*5/291)), the intensity percentage of the distance clamped to
// 12..46 cm, the PWM compare level (0..229), an out-of-range flag and the
// status LED level. Out-of-range readings toggle the LED when at least
// blink_interval_ms (written through i_cfg_we/i_cfg_wdata, reset 100) has
// passed since the last toggle, using the wrapped 32-bit time difference.
// A front stage takes one request per cycle while the queue is not full and
// converts it with a single reciprocal multiply; a two-entry queue feeds a
// two-stage back end (intensity and LED update, then PWM multiply into the
// output register). Sustained rate is one request per cycle without stalls;
// a result passes through the front register, the queue and the intensity
// stage into the output register and is then held there until taken.
module echo_range_to_pwm_level (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_pulse_us,
    input  logic [31:0] i_time_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_distance_cm,
    output logic [6:0]  o_intensity_pct,
    output logic [7:0]  o_pwm_level,
    output logic        o_out_of_range,
    output logic        o_status_led
);

    erpl_pkg::t_q_status q_status;
    erpl_pkg::t_entry    push_entry;
    erpl_pkg::t_entry    head_entry;
    logic                push;
    logic                pop;

    // Accept and classify requests
    erpl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pulse_us (i_pulse_us),
        .i_time_ms  (i_time_ms),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Decouple front and back
    erpl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    // Compute levels and drive results
    erpl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_status      (q_status),
        .i_entry         (head_entry),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_distance_cm   (o_distance_cm),
        .o_intensity_pct (o_intensity_pct),
        .o_pwm_level     (o_pwm_level),
        .o_out_of_range  (o_out_of_range),
        .o_status_led    (o_status_led)
    );

endmodule

### rtl/core/erpl_front.sv
module erpl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_pulse_us,
    input  logic [31:0]        i_time_ms,
    input  erpl_pkg::t_q_status i_q_status,
    output logic               o_push,
    output erpl_pkg::t_entry   o_entry
);

    logic        r_vld;
    logic [15:0] r_pulse;
    logic [31:0] r_time;
    logic        accept;
    logic [37:0] prod;
    logic [10:0] dist_cm;

    // Hold the request until the queue takes it
    assign o_push  = r_vld && !i_q_status.full;
    assign o_stall = r_vld && i_q_status.full;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pulse <= i_pulse_us;
            r_time  <= i_time_ms;
        end
    end

    // Convert echo width to distance by reciprocal multiply
    assign prod    = 38'(r_pulse) * 38'(erpl_pkg::DIST_MAGIC);
    assign dist_cm = prod[erpl_pkg::DIST_SHIFT +: 11];

    // Classify against the window and clamp
    always_comb begin
        o_entry.dist_cm = dist_cm;
        o_entry.time_ms = r_time;
        priority if (dist_cm < erpl_pkg::DIST_MIN_CM) begin
            o_entry.offset  = 6'd0;
            o_entry.outside = 1'b1;
        end else if (dist_cm > erpl_pkg::DIST_MAX_CM) begin
            o_entry.offset  = erpl_pkg::SPAN_CM;
            o_entry.outside = 1'b1;
        end else begin
            o_entry.offset  = 6'(dist_cm - erpl_pkg::DIST_MIN_CM);
            o_entry.outside = 1'b0;
        end
    end

endmodule

### rtl/core/erpl_queue.sv
module erpl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  erpl_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output erpl_pkg::t_entry    o_entry,
    output erpl_pkg::t_q_status o_status
);

    localparam int AW = (erpl_pkg::Q_DEPTH > 1) ? $clog2(erpl_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(erpl_pkg::Q_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(erpl_pkg::Q_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(erpl_pkg::Q_DEPTH);

    erpl_pkg::t_entry r_mem [erpl_pkg::Q_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FULL);
    assign o_entry        = r_mem[r_rd_ptr];

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/erpl_back.sv
module erpl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  erpl_pkg::t_q_status i_q_status,
    input  erpl_pkg::t_entry    i_entry,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [10:0]         o_distance_cm,
    output logic [6:0]          o_intensity_pct,
    output logic [7:0]          o_pwm_level,
    output logic                o_out_of_range,
    output logic                o_status_led
);

    logic [15:0] r_interval;
    logic        r_blink;
    logic [31:0] r_last_ms;

    logic        r_a_vld;
    logic [10:0] r_a_dist;
    logic [6:0]  r_a_pct;
    logic        r_a_out;
    logic        r_a_led;

    logic        r_o_vld;
    logic        out_free;
    logic        a_adv;
    logic        a_free;
    logic [31:0] elapsed;
    logic        toggle;
    logic [23:0] pct_prod;
    logic [30:0] pwm_prod;

    // Stage handshakes
    assign out_free = !r_o_vld || !i_stall;
    assign a_adv    = r_a_vld && out_free;
    assign a_free   = !r_a_vld || a_adv;
    assign o_pop    = !i_q_status.empty && a_free;
    assign o_valid  = r_o_vld;

    // Blink interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= erpl_pkg::BLINK_INTERVAL_RST;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
        end
    end

    // Decide the LED toggle on the wrapped elapsed time
    assign elapsed = i_entry.time_ms - r_last_ms;
    assign toggle  = i_entry.outside && (elapsed >= 32'(r_interval));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink   <= 1'b0;
            r_last_ms <= '0;
        end else if (o_pop && toggle) begin
            r_blink   <= !r_blink;
            r_last_ms <= i_entry.time_ms;
        end
    end

    // Intensity by reciprocal multiply
    assign pct_prod = 24'(i_entry.offset) * 24'(erpl_pkg::PCT_MAGIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (o_pop) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_dist <= i_entry.dist_cm;
            r_a_pct  <= pct_prod[erpl_pkg::PCT_SHIFT +: 7];
            r_a_out  <= i_entry.outside;
            r_a_led  <= toggle ? !r_blink : r_blink;
        end
    end

    // PWM level by reciprocal multiply
    assign pwm_prod = 31'(r_a_pct) * 31'(erpl_pkg::PWM_MAGIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (a_adv) begin
            r_o_vld <= 1'b1;
        end else if (out_free) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            o_distance_cm   <= r_a_dist;
            o_intensity_pct <= r_a_pct;
            o_pwm_level     <= pwm_prod[erpl_pkg::PWM_SHIFT +: 8];
            o_out_of_range  <= r_a_out;
            o_status_led    <= r_a_led;
        end
    end

endmodule
